// ===== rtl/sha256_pkg.sv =====
`default_nettype none

package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	typedef enum logic [1:0] {
		Q_WORD,
		Q_END,
		Q_WORD_END
	} q_kind_t;

	// Queue entry between front and back. For Q_END, data holds the tail bytes
	// left-justified and nbytes counts them; bitlen is the message length in bits.
	typedef struct packed {
		q_kind_t     kind;
		logic [31:0] data;
		logic [1:0]  nbytes;
		logic [63:0] bitlen;
	} q_item_t;

	typedef enum logic [1:0] {
		LD_MSG,
		LD_MARK,
		LD_ZERO,
		LD_LENLO
	} ld_state_t;

	typedef enum logic [1:0] {
		EN_IDLE,
		EN_RUN,
		EN_ADD,
		EN_OUT
	} en_state_t;

	typedef struct packed {
		en_state_t  estate;
		logic [5:0] rnd;
		logic [4:0] ld_cnt;
		logic       xfer;
	} back_status_t;

	localparam logic [4:0]  BLOCK_WORDS = 5'd16;
	localparam logic [4:0]  LEN_SLOT    = 5'd14;
	localparam logic [5:0]  LAST_ROUND  = 6'd63;
	localparam logic [2:0]  LAST_WORD   = 3'd7;
	localparam logic [31:0] PAD_MARK    = 32'h8000_0000;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_fifo.sv =====
`default_nettype none

module sha256_fifo #(
	parameter int DEPTH = 4
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire sha256_pkg::q_item_t  wr_item,
	output logic                      full,
	output logic                      valid,
	output sha256_pkg::q_item_t       rd_item,
	input  wire                       pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sha256_pkg::q_item_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_item = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sha256_front.sv =====
`default_nettype none

module sha256_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         msg_valid,
	input  wire sha256_pkg::msg_item_t  msg_item,
	output logic                        msg_stall,
	input  wire                         q_full,
	output logic                        q_push,
	output sha256_pkg::q_item_t         q_item
);

	logic [60:0] cnt_q;
	logic [23:0] part_q;
	logic        accept, word_done;
	logic [1:0]  pos;
	logic [60:0] cnt_nx;
	logic [23:0] part_nx;

	assign msg_stall = q_full;
	assign accept    = msg_valid && !q_full;
	assign pos       = cnt_q[1:0];
	assign word_done = msg_item.has_byte && (pos == 2'd3);
	assign cnt_nx    = msg_item.has_byte ? cnt_q + 61'd1 : cnt_q;

	always_comb begin
		part_nx = part_q;
		if (msg_item.has_byte) begin
			case (pos)
				2'd0: part_nx[23:16] = msg_item.data_byte;
				2'd1: part_nx[15:8]  = msg_item.data_byte;
				2'd2: part_nx[7:0]   = msg_item.data_byte;
				default: part_nx = part_q;
			endcase
		end
	end

	// Push on every completed word and on the end of a message.
	always_comb begin
		q_push        = accept && (word_done || msg_item.last);
		q_item.bitlen = {cnt_nx, 3'b000};
		q_item.nbytes = cnt_nx[1:0];
		if (word_done) begin
			q_item.data = {part_q, msg_item.data_byte};
			q_item.kind = msg_item.last ? sha256_pkg::Q_WORD_END : sha256_pkg::Q_WORD;
		end else begin
			q_item.data = {part_nx, 8'h00};
			q_item.kind = sha256_pkg::Q_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= msg_item.last ? '0 : cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			part_q <= part_nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sha256_back.sv =====
`default_nettype none

module sha256_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       q_valid,
	input  wire sha256_pkg::q_item_t  q_item,
	output logic                      q_pop,
	output logic                      dig_valid,
	input  wire                       dig_stall,
	output sha256_pkg::dig_item_t     dig_item,
	output sha256_pkg::back_status_t  status
);

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// Keep the tail bytes, append the marker byte, clear the rest.
	function automatic logic [31:0] pad_word(input logic [31:0] d, input logic [1:0] n);
		logic [31:0] r;
		case (n)
			2'd0: r = sha256_pkg::PAD_MARK;
			2'd1: r = {d[31:24], 24'h80_0000};
			2'd2: r = {d[31:16], 16'h8000};
			default: r = {d[31:8], 8'h80};
		endcase
		return r;
	endfunction

	// Loader: assembles the next 16-word block while the rounds run.
	sha256_pkg::ld_state_t ld_st_q, ld_st_nx;
	logic [31:0] ld_q [16];
	logic [4:0]  ld_cnt_q;
	logic        ld_fin_q;
	logic [63:0] len_q;
	logic        ld_we, set_fin, ld_room;
	logic [31:0] ld_wd;

	// Round engine
	sha256_pkg::en_state_t en_st_q, en_st_nx;
	logic [31:0] chain_q [8];
	logic [31:0] vars_q [8];
	logic [31:0] win_q [16];
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        fin_q;
	logic        xfer, out_load;
	logic        dig_valid_q;
	logic [31:0] dig_word_q;
	logic [2:0]  dig_idx_q;

	logic [31:0] big_s0, big_s1, chv, majv, tmp1, tmp2, sg0, sg1, w_new;

	assign ld_room = (ld_cnt_q != sha256_pkg::BLOCK_WORDS);

	always_comb begin
		ld_st_nx = ld_st_q;
		ld_we    = 1'b0;
		ld_wd    = '0;
		q_pop    = 1'b0;
		set_fin  = 1'b0;
		if (ld_room) begin
			case (ld_st_q)
				sha256_pkg::LD_MSG: begin
					if (q_valid) begin
						q_pop = 1'b1;
						ld_we = 1'b1;
						case (q_item.kind)
							sha256_pkg::Q_END: begin
								ld_wd    = pad_word(q_item.data, q_item.nbytes);
								ld_st_nx = sha256_pkg::LD_ZERO;
							end
							sha256_pkg::Q_WORD_END: begin
								ld_wd    = q_item.data;
								ld_st_nx = sha256_pkg::LD_MARK;
							end
							default: ld_wd = q_item.data;
						endcase
					end
				end
				sha256_pkg::LD_MARK: begin
					ld_we    = 1'b1;
					ld_wd    = sha256_pkg::PAD_MARK;
					ld_st_nx = sha256_pkg::LD_ZERO;
				end
				sha256_pkg::LD_ZERO: begin
					ld_we = 1'b1;
					if (ld_cnt_q == sha256_pkg::LEN_SLOT) begin
						ld_wd    = len_q[63:32];
						ld_st_nx = sha256_pkg::LD_LENLO;
					end
				end
				sha256_pkg::LD_LENLO: begin
					ld_we    = 1'b1;
					ld_wd    = len_q[31:0];
					set_fin  = 1'b1;
					ld_st_nx = sha256_pkg::LD_MSG;
				end
				default: ld_st_nx = sha256_pkg::LD_MSG;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_st_q  <= sha256_pkg::LD_MSG;
			ld_cnt_q <= '0;
			ld_fin_q <= 1'b0;
		end else begin
			ld_st_q <= ld_st_nx;
			if (xfer) begin
				ld_cnt_q <= '0;
				ld_fin_q <= 1'b0;
			end else begin
				if (ld_we) begin
					ld_cnt_q <= ld_cnt_q + 5'd1;
				end
				if (set_fin) begin
					ld_fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			for (int i = 0; i < 15; i++) begin
				ld_q[i] <= ld_q[i+1];
			end
			ld_q[15] <= ld_wd;
		end
		if (q_pop && q_item.kind != sha256_pkg::Q_WORD) begin
			len_q <= q_item.bitlen;
		end
	end

	// One round per cycle; the schedule window shifts with the next word.
	always_comb begin
		big_s1 = rotr(vars_q[4], 6) ^ rotr(vars_q[4], 11) ^ rotr(vars_q[4], 25);
		chv    = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
		tmp1   = vars_q[7] + big_s1 + chv + sha256_pkg::round_k(rnd_q) + win_q[0];
		big_s0 = rotr(vars_q[0], 2) ^ rotr(vars_q[0], 13) ^ rotr(vars_q[0], 22);
		majv   = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
		tmp2   = big_s0 + majv;
		sg0    = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
		sg1    = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
		w_new  = win_q[0] + sg0 + win_q[9] + sg1;
	end

	assign xfer     = (en_st_q == sha256_pkg::EN_IDLE) && !ld_room;
	assign out_load = (en_st_q == sha256_pkg::EN_OUT) && (!dig_valid_q || !dig_stall);

	always_comb begin
		en_st_nx = en_st_q;
		case (en_st_q)
			sha256_pkg::EN_IDLE: begin
				if (xfer) begin
					en_st_nx = sha256_pkg::EN_RUN;
				end
			end
			sha256_pkg::EN_RUN: begin
				if (rnd_q == sha256_pkg::LAST_ROUND) begin
					en_st_nx = sha256_pkg::EN_ADD;
				end
			end
			sha256_pkg::EN_ADD: begin
				en_st_nx = fin_q ? sha256_pkg::EN_OUT : sha256_pkg::EN_IDLE;
			end
			sha256_pkg::EN_OUT: begin
				if (out_load && oidx_q == sha256_pkg::LAST_WORD) begin
					en_st_nx = sha256_pkg::EN_IDLE;
				end
			end
			default: en_st_nx = sha256_pkg::EN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_st_q     <= sha256_pkg::EN_IDLE;
			rnd_q       <= '0;
			oidx_q      <= '0;
			fin_q       <= 1'b0;
			dig_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256_pkg::init_h(3'(i));
			end
		end else begin
			en_st_q <= en_st_nx;
			if (xfer) begin
				rnd_q <= '0;
				fin_q <= ld_fin_q;
			end else if (en_st_q == sha256_pkg::EN_RUN) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (en_st_q == sha256_pkg::EN_ADD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + vars_q[i];
				end
			end
			// Shift the digest out; refill the chain with the initial values.
			if (out_load) begin
				for (int i = 0; i < 7; i++) begin
					chain_q[i] <= chain_q[i+1];
				end
				chain_q[7] <= sha256_pkg::init_h(oidx_q);
				oidx_q     <= oidx_q + 3'd1;
			end
			if (out_load) begin
				dig_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				dig_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			for (int i = 0; i < 16; i++) begin
				win_q[i] <= ld_q[i];
			end
			for (int i = 0; i < 8; i++) begin
				vars_q[i] <= chain_q[i];
			end
		end else if (en_st_q == sha256_pkg::EN_RUN) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
			vars_q[7] <= vars_q[6];
			vars_q[6] <= vars_q[5];
			vars_q[5] <= vars_q[4];
			vars_q[4] <= vars_q[3] + tmp1;
			vars_q[3] <= vars_q[2];
			vars_q[2] <= vars_q[1];
			vars_q[1] <= vars_q[0];
			vars_q[0] <= tmp1 + tmp2;
		end
		if (out_load) begin
			dig_word_q <= chain_q[0];
			dig_idx_q  <= oidx_q;
		end
	end

	assign dig_valid            = dig_valid_q;
	assign dig_item.digest_word = dig_word_q;
	assign dig_item.word_index  = dig_idx_q;
	assign dig_item.last_word   = (dig_idx_q == sha256_pkg::LAST_WORD);

	assign status.estate = en_st_q;
	assign status.rnd    = rnd_q;
	assign status.ld_cnt = ld_cnt_q;
	assign status.xfer   = xfer;

endmodule

`default_nettype wire

// ===== rtl/sha256_message_hasher.sv =====
// Throughput: one byte per cycle until the queue and loader fill; then the round engine sets
//   the pace: a handoff, 64 rounds and an add per 64-byte block, then the digest output.
// Latency: after the last item, the queue, the loader padding, the engine rounds and add of
//   each final block and the digest register come in turn, then the eight digest words
//   leave one per cycle while dig_stall is low.
// Reset: arst_n clears the byte count, queue, loader and engine; the chain returns to
//   the initial hash values. No item waits on a clearing pass.
`default_nettype none

module sha256_message_hasher #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          msg_valid,
	input  wire sha256_pkg::msg_item_t   msg_item,
	output logic                         msg_stall,
	output logic                         dig_valid,
	input  wire                          dig_stall,
	output sha256_pkg::dig_item_t        dig_item
);

	logic                     f_push, q_full, q_valid, q_pop;
	sha256_pkg::q_item_t      f_item, q_item;
	sha256_pkg::back_status_t st;

	sha256_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_item  (msg_item),
		.msg_stall (msg_stall),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_item    (f_item)
	);

	sha256_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_item (f_item),
		.full    (q_full),
		.valid   (q_valid),
		.rd_item (q_item),
		.pop     (q_pop)
	);

	sha256_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig_item  (dig_item),
		.status    (st)
	);

	a_ld_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.ld_cnt <= sha256_pkg::BLOCK_WORDS)
		else $error("loader count past block size");

	a_xfer_run: assert property (@(posedge clk) disable iff (!arst_n)
		st.xfer |=> (st.estate == sha256_pkg::EN_RUN) && (st.rnd == 6'd0))
		else $error("block handoff did not start the rounds");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig_item.last_word == (dig_item.word_index == sha256_pkg::LAST_WORD)))
		else $error("last word flag disagrees with word index");

	a_word_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_stall && !dig_item.last_word) ##1 dig_valid
		|-> dig_item.word_index == $past(dig_item.word_index) + 3'd1)
		else $error("digest words out of order");

endmodule

`default_nettype wire
